>>> rtl/posp_pkg.sv
// Package for the presorted order split partition block.
// Shared constants, operation codes and the engine item and result structs.
package posp_pkg;
    localparam int SAMPLE_W  = 10;
    localparam int FEATURE_W = 4;
    localparam int FCOUNT_W  = 5;
    localparam int ADDR_W    = FEATURE_W + SAMPLE_W;
    localparam int NUM_FEATURES = 16;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_SPLIT = 2'd2;

    typedef struct packed {
        logic [1:0]           op;
        logic [FEATURE_W-1:0] feature;
        logic [SAMPLE_W-1:0]  position;
        logic [SAMPLE_W-1:0]  sample_id;
        logic [SAMPLE_W-1:0]  lo;
        logic [SAMPLE_W-1:0]  hi;
        logic [SAMPLE_W-1:0]  cut;
        logic [FEATURE_W-1:0] sf;
    } item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] read_sample;
        logic [SAMPLE_W-1:0] read_rank;
        logic                status;
    } result_t;
endpackage

>>> rtl/posp_ram.sv
// Generic single-port-write, single-read synchronous RAM with registered read data.
// No dependencies.
module posp_ram #(
    parameter int DATA_W = 10,
    parameter int ADDR_W = 14
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);
    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/posp_engine.sv
// Sequencer for write, read and split items over the sample and rank RAMs.
// Depends on posp_pkg and posp_ram.
module posp_engine
    import posp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  item_t               item,
    input  logic [FCOUNT_W-1:0] feature_count,
    output logic                busy,
    output logic                done,
    output result_t             result
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDWAIT = 4'd1;
    localparam logic [3:0] S_CLR   = 4'd2;
    localparam logic [3:0] S_MRK0  = 4'd3;
    localparam logic [3:0] S_MRK1  = 4'd4;
    localparam logic [3:0] S_MRK2  = 4'd5;
    localparam logic [3:0] S_PRT0  = 4'd6;
    localparam logic [3:0] S_PRT1  = 4'd7;
    localparam logic [3:0] S_CPY0  = 4'd8;
    localparam logic [3:0] S_CPY1  = 4'd9;
    localparam logic [3:0] S_NEXT  = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0]           state_reg, state_next;
    item_t                item_reg;
    logic [FEATURE_W-1:0] f_reg, f_next;
    logic [SAMPLE_W:0]    j_reg, j_next;
    logic [SAMPLE_W:0]    wl_reg, wl_next, wr_reg, wr_next;
    logic                 status_reg, status_next;
    logic                 fdone_reg, fdone_next;

    // sorted samples RAM
    logic                ss_we;
    logic [ADDR_W-1:0]   ss_waddr, ss_raddr;
    logic [SAMPLE_W-1:0] ss_wdata, ss_rdata;
    // rank RAM
    logic                rk_we;
    logic [ADDR_W-1:0]   rk_waddr, rk_raddr;
    logic [SAMPLE_W-1:0] rk_wdata, rk_rdata;
    // partition buffer
    logic                pb_we;
    logic [SAMPLE_W-1:0] pb_waddr, pb_raddr, pb_wdata, pb_rdata;
    // marks, cleared over the range by a sweep
    logic                mk_we;
    logic [SAMPLE_W-1:0] mk_waddr, mk_raddr;
    logic                mk_wdata, mk_rdata;
    logic                mark [2**SAMPLE_W];

    posp_ram #(.DATA_W(SAMPLE_W), .ADDR_W(ADDR_W)) u_ss (
        .clk(clk), .we(ss_we), .waddr(ss_waddr), .wdata(ss_wdata),
        .raddr(ss_raddr), .rdata(ss_rdata));
    posp_ram #(.DATA_W(SAMPLE_W), .ADDR_W(ADDR_W)) u_rk (
        .clk(clk), .we(rk_we), .waddr(rk_waddr), .wdata(rk_wdata),
        .raddr(rk_raddr), .rdata(rk_rdata));
    posp_ram #(.DATA_W(SAMPLE_W), .ADDR_W(SAMPLE_W)) u_pb (
        .clk(clk), .we(pb_we), .waddr(pb_waddr), .wdata(pb_wdata),
        .raddr(pb_raddr), .rdata(pb_rdata));

    // marks need no reset: every split clears its range before it marks,
    // and only positions inside that range are read back
    always_ff @(posedge clk)
    begin
        if (mk_we)
        begin
            mark[mk_waddr] <= mk_wdata;
        end
        mk_rdata <= mark[mk_raddr];
    end

    logic [SAMPLE_W-1:0] j_lo;
    logic [FCOUNT_W-1:0] n_act;
    logic [FEATURE_W-1:0] f_inc;
    logic                last_f;
    assign j_lo  = j_reg[SAMPLE_W-1:0];
    assign n_act = (feature_count > FCOUNT_W'(NUM_FEATURES)) ?
                   FCOUNT_W'(NUM_FEATURES) : feature_count;
    assign f_inc = f_reg + FEATURE_W'(1);
    assign last_f = ({1'b0, f_reg} + FCOUNT_W'(1)) >= n_act;

    always_comb
    begin
        state_next  = state_reg;
        f_next      = f_reg;
        j_next      = j_reg;
        wl_next     = wl_reg;
        wr_next     = wr_reg;
        status_next = status_reg;
        fdone_next  = fdone_reg;
        ss_we = 1'b0; ss_waddr = '0; ss_wdata = '0; ss_raddr = '0;
        rk_we = 1'b0; rk_waddr = '0; rk_wdata = '0; rk_raddr = '0;
        pb_we = 1'b0; pb_waddr = '0; pb_wdata = '0; pb_raddr = '0;
        mk_we = 1'b0; mk_waddr = '0; mk_wdata = 1'b0; mk_raddr = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    status_next = 1'b1;
                    case (item.op)
                        OP_WRITE:
                        begin
                            ss_we = 1'b1;
                            ss_waddr = {item.feature, item.position};
                            ss_wdata = item.sample_id;
                            rk_we = 1'b1;
                            rk_waddr = {item.feature, item.sample_id};
                            rk_wdata = item.position;
                            status_next = 1'b0;
                            state_next = S_DONE;
                        end
                        OP_READ:
                        begin
                            ss_raddr = {item.feature, item.position};
                            rk_raddr = {item.feature, item.sample_id};
                            status_next = 1'b0;
                            state_next = S_RDWAIT;
                        end
                        OP_SPLIT:
                        begin
                            if (item.lo <= item.cut && item.cut <= item.hi &&
                                {1'b0, item.sf} < n_act)
                            begin
                                status_next = 1'b0;
                                f_next = '0;
                                state_next = S_NEXT;
                                fdone_next = 1'b0;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_RDWAIT:
            begin
                state_next = S_DONE;
            end
            S_NEXT:
            begin
                // pick feature f_reg, skipping the split feature
                if (fdone_reg)
                begin
                    state_next = S_DONE;
                end
                else if (f_reg == item_reg.sf)
                begin
                    if (last_f)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        f_next = f_inc;
                    end
                end
                else
                begin
                    j_next = {1'b0, item_reg.lo};
                    state_next = S_CLR;
                end
            end
            S_CLR:
            begin
                mk_we = 1'b1;
                mk_waddr = j_lo;
                mk_wdata = 1'b0;
                if (j_lo == item_reg.hi)
                begin
                    j_next = {1'b0, item_reg.lo};
                    state_next = S_MRK0;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_MRK0:
            begin
                ss_raddr = {item_reg.sf, j_lo};
                state_next = S_MRK1;
            end
            S_MRK1:
            begin
                rk_raddr = {f_reg, ss_rdata};
                state_next = S_MRK2;
            end
            S_MRK2:
            begin
                mk_we = 1'b1;
                mk_waddr = rk_rdata;
                mk_wdata = 1'b1;
                if (j_lo == item_reg.cut)
                begin
                    j_next = {1'b0, item_reg.lo};
                    wl_next = {1'b0, item_reg.lo};
                    wr_next = {1'b0, item_reg.cut} + 1'b1;
                    state_next = S_PRT0;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                    state_next = S_MRK0;
                end
            end
            S_PRT0:
            begin
                ss_raddr = {f_reg, j_lo};
                mk_raddr = j_lo;
                state_next = S_PRT1;
            end
            S_PRT1:
            begin
                pb_we = 1'b1;
                pb_wdata = ss_rdata;
                if (mk_rdata)
                begin
                    pb_waddr = wl_reg[SAMPLE_W-1:0];
                    pb_we = !wl_reg[SAMPLE_W];
                    wl_next = wl_reg + 1'b1;
                end
                else
                begin
                    pb_waddr = wr_reg[SAMPLE_W-1:0];
                    pb_we = !wr_reg[SAMPLE_W];
                    wr_next = wr_reg + 1'b1;
                end
                if (j_lo == item_reg.hi)
                begin
                    j_next = {1'b0, item_reg.lo};
                    state_next = S_CPY0;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                    state_next = S_PRT0;
                end
            end
            S_CPY0:
            begin
                pb_raddr = j_lo;
                state_next = S_CPY1;
            end
            S_CPY1:
            begin
                ss_we = 1'b1;
                ss_waddr = {f_reg, j_lo};
                ss_wdata = pb_rdata;
                rk_we = 1'b1;
                rk_waddr = {f_reg, pb_rdata};
                rk_wdata = j_lo;
                if (j_lo == item_reg.hi)
                begin
                    state_next = S_NEXT;
                    if (last_f)
                    begin
                        fdone_next = 1'b1;
                    end
                    else
                    begin
                        f_next = f_inc;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                    state_next = S_CPY0;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    logic [SAMPLE_W-1:0] rs_reg, rr_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            item_reg <= item;
        end
        f_reg      <= f_next;
        j_reg      <= j_next;
        wl_reg     <= wl_next;
        wr_reg     <= wr_next;
        status_reg <= status_next;
        fdone_reg  <= fdone_next;
        if (state_reg == S_IDLE)
        begin
            rs_reg <= '0;
            rr_reg <= '0;
        end
        else if (state_reg == S_RDWAIT)
        begin
            rs_reg <= ss_rdata;
            rr_reg <= rk_rdata;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);
    assign result.read_sample = rs_reg;
    assign result.read_rank   = rr_reg;
    assign result.status      = status_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start)) else $error("done without work");
    a_write_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start && item.op == OP_WRITE) |=> done)
        else $error("write took too long");
    a_ptr_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PRT1) |-> (wl_reg <= wr_reg))
        else $error("left pointer passed right pointer");
endmodule

>>> rtl/presorted_order_split_partition.sv
// Top level of the presorted order split partition block.
// Depends on posp_pkg and posp_engine.
//
// One transaction in gives one result transaction out. A write updates the
// sample and rank RAMs, a read returns the stored sample and rank, and an
// invalid item returns status 1. A split walks each active feature other
// than the split feature: it clears the marks over node_lo..node_hi, marks
// the samples up to cut_index in split-feature order, partitions the
// feature's entries into a buffer and copies them back to the sample and
// rank RAMs.
// The block takes one item at a time; a result waits in the output register
// and the next item is accepted as soon as that register is taken.
module presorted_order_split_partition
    import posp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // feature[3:0], position[13:4], sample_id[23:14],
    // node_lo[33:24], node_hi[43:34], cut_index[53:44],
    // split_feature[57:54]
    input  logic [63:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_sample[9:0], read_rank[19:10]
    output logic [23:0] m_tdata,
    // status[0]
    output logic        m_tuser
);
    logic [FCOUNT_W-1:0] feature_count_reg;
    item_t   item;
    result_t result;
    logic    busy, done, start;
    logic    out_valid_reg;
    result_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feature_count_reg <= FCOUNT_W'(NUM_FEATURES);
        end
        else if (cfg_we)
        begin
            feature_count_reg <= cfg_wdata;
        end
    end

    assign item.op        = s_tuser;
    assign item.feature   = s_tdata[3:0];
    assign item.position  = s_tdata[13:4];
    assign item.sample_id = s_tdata[23:14];
    assign item.lo        = s_tdata[33:24];
    assign item.hi        = s_tdata[43:34];
    assign item.cut       = s_tdata[53:44];
    assign item.sf        = s_tdata[57:54];

    // accept only when engine idle and output register free
    assign s_tready = !busy && !out_valid_reg;
    assign start    = s_tvalid && s_tready;

    posp_engine u_engine (
        .clk(clk), .rst_n(rst_n), .start(start), .item(item),
        .feature_count(feature_count_reg), .busy(busy), .done(done),
        .result(result));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.read_rank, out_reg.read_sample};
    assign m_tuser  = out_reg.status;

    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !start) else $error("accepted over pending result");
    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !out_valid_reg) else $error("result overwritten");
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy) else $error("engine missed start");
endmodule
